// ----- hw/rtl/rthsi_pkg.sv -----
`default_nettype none
package rthsi_pkg;

    localparam int XW         = 44;   // CORDIC x/y datapath width
    localparam int ZW         = 30;   // angle accumulator, 2^-20 degree units
    localparam int STEPS      = 24;
    localparam int QBITS      = 16;   // saturation quotient bits
    localparam int SW         = 10;   // channel sum width
    localparam int DW         = 11;   // saturation divisor width
    localparam int RW         = 12;   // partial remainder width

    localparam logic [XW-1:0] SQRT3_Q30    = 44'd1859775393;
    localparam logic [ZW-1:0] ANG_90       = 30'd94371840;
    localparam logic [ZW-1:0] ANG_180      = 30'd188743680;
    localparam logic [15:0]   HUE_HALF     = 16'd23040;
    localparam logic [15:0]   HUE_FULL     = 16'd46080;
    localparam logic [19:0]   RECIP3_Q20   = 20'd349526;

    typedef logic [ZW-1:0] atan_tab_t [STEPS];

    // atan(2^-i) in degrees, scaled by 2^20
    localparam atan_tab_t ATAN_TAB = '{
        30'd47185920, 30'd27855475, 30'd14718068, 30'd7471121, 30'd3750058,
        30'd1876857, 30'd938658, 30'd469357, 30'd234682, 30'd117342,
        30'd58671, 30'd29335, 30'd14668, 30'd7334, 30'd3667, 30'd1833,
        30'd917, 30'd458, 30'd229, 30'd115, 30'd57, 30'd29, 30'd14, 30'd7
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [RW-1:0]        rem;
        logic [QBITS-1:0]     quo;
        logic [DW-1:0]        dvs;
        logic [SW-1:0]        sum;
        logic [15:0]          inten;
        logic                 gray;
        logic                 y_zero;
        logic                 x_pos;
        logic                 mirror;
    } hsi_word_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rthsi_front.sv -----
`default_nettype none
module rthsi_front
    import rthsi_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output logic           out_valid,
    input  wire logic      out_ready,
    output hsi_word_t      out_word
);

    // stage one: sums, minimum, intensity, hue sign flags
    logic             v1_reg;
    logic signed [10:0] x0_reg, x0_next;
    logic [7:0]       d_reg, d_next;
    logic [SW-1:0]    s_reg, s_next;
    logic [SW-1:0]    num_reg, num_next;
    logic [15:0]      inten_reg, inten_next;
    logic             gray_reg, mirror_reg, xpos_reg;
    logic             rdy1;

    logic [7:0]  mn;
    logic [17:0] iv;
    logic [37:0] iprod;

    always_comb begin
        mn = (red < green) ? red : green;
        if (blue < mn) mn = blue;
        s_next = SW'(red) + SW'(green) + SW'(blue);
        num_next = s_next - 10'(3 * {2'b0, mn});
        iv = {s_next, 8'd0} + 18'd1;
        iprod = 38'(iv) * 38'(RECIP3_Q20);
        inten_next = iprod[35:20];
        x0_next = $signed({2'b0, red, 1'b0}) - $signed({3'b0, green})
                  - $signed({3'b0, blue});
        d_next = (green >= blue) ? (green - blue) : (blue - green);
    end

    // stage two: scale, pre-rotate left half-plane vectors, seed divider
    logic             v2_reg;
    hsi_word_t        w2_reg, w2_next;
    logic signed [XW-1:0] xs, ys;

    assign out_valid = v2_reg;
    assign out_word  = w2_reg;
    logic rdy2;
    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        xs = $signed({{(XW-11){x0_reg[10]}}, x0_reg}) <<< 30;
        ys = $signed(XW'(d_reg) * SQRT3_Q30);
        w2_next = '0;
        if (x0_reg < 0) begin
            w2_next.x = ys;
            w2_next.y = -xs;
            w2_next.z = ANG_90;
        end else begin
            w2_next.x = xs;
            w2_next.y = ys;
            w2_next.z = '0;
        end
        w2_next.rem    = RW'(num_reg);
        w2_next.quo    = '0;
        w2_next.dvs    = (s_reg == '0) ? DW'(1) : {s_reg, 1'b0};
        w2_next.sum    = s_reg;
        w2_next.inten  = inten_reg;
        w2_next.gray   = gray_reg;
        w2_next.y_zero = (d_reg == 8'd0);
        w2_next.x_pos  = xpos_reg;
        w2_next.mirror = mirror_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
        end
        if (rdy1 && in_valid) begin
            x0_reg     <= x0_next;
            d_reg      <= d_next;
            s_reg      <= s_next;
            num_reg    <= num_next;
            inten_reg  <= inten_next;
            gray_reg   <= (red == green) && (green == blue);
            mirror_reg <= blue > green;
            xpos_reg   <= x0_next > 0;
        end
        if (rdy2 && v1_reg) w2_reg <= w2_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/rthsi_cell.sv -----
`default_nettype none
module rthsi_cell
    import rthsi_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire hsi_word_t in_word,
    output logic       out_valid,
    input  wire logic  out_ready,
    output hsi_word_t  out_word
);

    logic      valid_reg;
    hsi_word_t word_reg, word_next;
    logic signed [XW-1:0] sx, sy;
    logic [RW-1:0] r2;
    logic [15:0]   sum_ext;

    always_comb begin
        word_next = in_word;
        sx = in_word.x >>> IDX;
        sy = in_word.y >>> IDX;
        // rotate toward the x axis
        if (!in_word.y[XW-1] && (in_word.y != '0)) begin
            word_next.x = in_word.x + sy;
            word_next.y = in_word.y - sx;
            word_next.z = in_word.z + $signed(ATAN_TAB[IDX]);
        end else begin
            word_next.x = in_word.x - sy;
            word_next.y = in_word.y + sx;
            word_next.z = in_word.z - $signed(ATAN_TAB[IDX]);
        end
        // one restoring-division bit for saturation
        sum_ext = 16'(in_word.sum);
        r2 = {in_word.rem[RW-2:0], sum_ext[(IDX < QBITS) ? (QBITS-1-IDX) : 0]};
        if (IDX < QBITS) begin
            if (r2 >= RW'(in_word.dvs)) begin
                word_next.rem = r2 - RW'(in_word.dvs);
                word_next.quo = {in_word.quo[QBITS-2:0], 1'b1};
            end else begin
                word_next.rem = r2;
                word_next.quo = {in_word.quo[QBITS-2:0], 1'b0};
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) word_reg <= word_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/rgb_to_hsi_pixel.sv -----
`default_nettype none
// RGB to HSI pixel converter. One pixel enters per clock and passes through
// two input stages, a row of 24 CORDIC cells (the first 16 also producing one
// saturation quotient bit each), and an output register. Throughput is
// one pixel per cycle; a stalled output only blocks input once every stage
// is full. Hue is Q9.7 degrees, saturation Q1.15, intensity Q8.8.
module rgb_to_hsi_pixel
    import rthsi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // hue[15:0], saturation[31:16], intensity[47:32]
);

    logic      cv [STEPS+1];
    logic      cr [STEPS+1];
    hsi_word_t cw [STEPS+1];

    rthsi_front u_front (
        .aclk, .aresetn,
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .red      (s_tdata[7:0]),
        .green    (s_tdata[15:8]),
        .blue     (s_tdata[23:16]),
        .out_valid(cv[0]),
        .out_ready(cr[0]),
        .out_word (cw[0])
    );

    for (genvar i = 0; i < STEPS; i++) begin : g_cell
        rthsi_cell #(.IDX(i)) u_cell (
            .aclk, .aresetn,
            .in_valid (cv[i]),
            .in_ready (cr[i]),
            .in_word  (cw[i]),
            .out_valid(cv[i+1]),
            .out_ready(cr[i+1]),
            .out_word (cw[i+1])
        );
    end

    hsi_word_t         wl;
    logic [ZW-2:0]     zc;
    logic [ZW-2:0]     zr;
    logic [15:0]       theta;
    logic [47:0]       dout_reg, dout_next;
    logic              mv_reg;

    always_comb begin
        wl = cw[STEPS];
        if (wl.z < 0)
            zc = '0;
        else if (wl.z > $signed(ANG_180))
            zc = ANG_180[ZW-2:0];
        else
            zc = wl.z[ZW-2:0];
        zr = zc + (ZW-1)'(4096);
        theta = 16'(zr >> 13);
        if (wl.y_zero)
            theta = wl.x_pos ? 16'd0 : HUE_HALF;
        if (wl.gray)
            theta = 16'd0;
        else if (wl.mirror)
            theta = HUE_FULL - theta;
        dout_next = {wl.inten, wl.quo, theta};
    end

    assign cr[STEPS] = !mv_reg || m_tready;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = dout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cr[STEPS]) begin
            mv_reg <= cv[STEPS];
        end
        if (cr[STEPS] && cv[STEPS]) dout_reg <= dout_next;
    end

    // input backpressure only ever comes from a stalled, full output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] < HUE_FULL))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:16] <= 16'd32768))
        else $error("saturation out of range");

    a_int_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:32] <= 16'd65280))
        else $error("intensity out of range");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] inten;
        logic [15:0] sat;
        logic [15:0] hue;
    } hsi_t;

    localparam longint ONE_DEG = 64'd1048576;
    localparam longint SQRT3_Q30 = 64'd1859775393;
    localparam longint X_SCALE = 64'd1073741824;
    localparam int LATENCY = 27;
    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;

    hsi_t expected_hsi[$];
    int error_count = 0;
    int cycle_count = 0;
    bit rx_stall_on = 1'b1;

    longint atan_deg[24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    rgb_to_hsi_pixel uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    // theta in Q9.7 degrees for y >= 0
    function automatic logic [15:0] vector_angle(longint x, longint y);
        longint z, t, sx, sy;
        z = 0;
        if (y == 0) return (x > 0) ? 16'd0 : 16'd23040;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 90 * ONE_DEG;
        end
        for (int i = 0; i < 24; i++) begin
            sx = floor_shr(x, i);
            sy = floor_shr(y, i);
            if (y > 0) begin
                x += sy;
                y -= sx;
                z += atan_deg[i];
            end else begin
                x -= sy;
                y += sx;
                z -= atan_deg[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 180 * ONE_DEG) z = 180 * ONE_DEG;
        return 16'((z + 4096) >>> 13);
    endfunction

    function automatic hsi_t pixel_to_hsi(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        hsi_t h;
        longint s, m, d, x;
        logic [15:0] theta;
        s = r + g + b;
        m = (r < g) ? r : g;
        if (b < m) m = b;
        h.inten = 16'((256 * s + 1) / 3);
        h.sat = (s == 0) ? 16'd0 : 16'((65536 * (s - 3 * m) + s) / (2 * s));
        if (r == g && g == b) begin
            h.hue = 16'd0;
        end else begin
            x = (2 * longint'(r) - g - b) * X_SCALE;
            d = (g >= b) ? longint'(g) - b : longint'(b) - g;
            theta = vector_angle(x, d * SQRT3_Q30);
            h.hue = (g >= b) ? theta : 16'd46080 - theta;
        end
        return h;
    endfunction

    task automatic report_error(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // drive one word and hold until accepted; valid stays high into the next word unless an idle gap is drawn
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit idle_gaps);
        int gap;
        gap = idle_gaps ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {b, g, r};
        s_tvalid <= 1'b1;
        expected_hsi.push_back(pixel_to_hsi(r, g, b));
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // check each word; random stall on the result side while rx_stall_on is set
    always @(posedge aclk) begin
        hsi_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_hsi.size() == 0) begin
                report_error("unexpected word", got.hue, 16'd0);
            end else begin
                want = expected_hsi.pop_front();
                if (got.hue !== want.hue) report_error("hue", got.hue, want.hue);
                if (got.sat !== want.sat) report_error("saturation", got.sat, want.sat);
                if (got.inten !== want.inten)
                    report_error("intensity", got.inten, want.inten);
            end
        end
        m_tready <= rx_stall_on ? ($urandom_range(0, 9) < 7) : 1'b1;
    end

    task automatic test_extremes();
        logic [7:0] v[4] = '{8'd0, 8'd1, 8'd128, 8'd255};
        for (int i = 0; i < 4; i++) begin
            send_pixel(v[i], v[i], v[i], 1'b1);
        end
        send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd10, 8'd10, 1'b1);
        send_pixel(8'd10, 8'd200, 8'd200, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd1, 1'b1);
        send_pixel(8'd0, 8'd1, 8'd0, 1'b1);
        send_pixel(8'd1, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd100, 8'd50, 8'd51, 1'b1);
        send_pixel(8'd100, 8'd51, 8'd50, 1'b1);
        send_pixel(8'd85, 8'd170, 8'd255, 1'b1);
        send_pixel(8'd170, 8'd85, 8'd0, 1'b1);
    endtask

    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (expected_hsi.size() != 0) @(posedge aclk);
    endtask

    task automatic test_random_pixels(int n, bit idle_gaps);
        logic [7:0] r, g, b;
        for (int i = 0; i < n; i++) begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            // steer some toward gray and near-gray corners
            case ($urandom_range(0, 9))
                0: g = b;
                1: begin g = r; b = r; end
                2: b = g + 8'($urandom_range(0, 2)) - 8'd1;
                default: ;
            endcase
            send_pixel(r, g, b, idle_gaps);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_drain_pause();
        test_random_pixels(350, 1'b1);
        rx_stall_on = 1'b0;
        test_random_pixels(150, 1'b0);
        rx_stall_on = 1'b1;
        test_random_pixels(300, 1'b1);
        test_drain_pause();
        repeat (LATENCY + 5) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
